>>> hdl/sql_risk_token_scan_macros.svh
// Assertion macros shared by the checker of the SQL risk token scanner.
`ifndef SQL_RISK_TOKEN_SCAN_MACROS_SVH
`define SQL_RISK_TOKEN_SCAN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/srts_pkg.sv
// Types, codes and character classes of the SQL risk token scanner.
package srts_pkg;

    typedef enum logic [2:0] {
        REASON_NONE    = 3'd0,
        REASON_SPECIAL = 3'd1,
        REASON_OR      = 3'd2,
        REASON_UNION   = 3'd3,
        REASON_AND     = 3'd4,
        REASON_IN      = 3'd5,
        REASON_NOT     = 3'd6
    } reason_t;

    localparam int unsigned WORD_BYTES = 5;
    localparam int unsigned WORD_W     = 8 * WORD_BYTES;
    localparam logic [2:0]  LEN_LONG   = 3'd6;

    localparam int unsigned HIT_OR    = 0;
    localparam int unsigned HIT_UNION = 1;
    localparam int unsigned HIT_AND   = 2;
    localparam int unsigned HIT_IN    = 3;
    localparam int unsigned HIT_NOT   = 4;
    localparam int unsigned HITS_W    = 5;

    localparam logic [WORD_W-1:0] KW_OR    = 40'h00_0000_6F72;
    localparam logic [WORD_W-1:0] KW_UNION = 40'h75_6E69_6F6E;
    localparam logic [WORD_W-1:0] KW_AND   = 40'h00_0061_6E64;
    localparam logic [WORD_W-1:0] KW_IN    = 40'h00_0000_696E;
    localparam logic [WORD_W-1:0] KW_NOT   = 40'h00_006E_6F74;

    typedef struct packed {
        logic       fire;
        logic [7:0] char_byte;
        logic       char_valid;
        logic       last;
    } step_t;

    typedef struct packed {
        logic    risky;
        reason_t reason;
    } verdict_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_word_byte(input logic [7:0] c);
        return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F});
    endfunction

    function automatic logic is_special_byte(input logic [7:0] c);
        return (c inside {8'h27, 8'h5F, 8'h2D, 8'h2B, 8'h2F, 8'h3D, 8'h3C, 8'h3E,
                          8'h28, 8'h29, 8'h2C, 8'h2E, 8'h3F, 8'h3A, 8'h7C, 8'h5B,
                          8'h5D, 8'h7B, 8'h7D, 8'h40, 8'h23, 8'h24, 8'h25, 8'h26,
                          8'h21, 8'h5E});
    endfunction

    function automatic logic [HITS_W-1:0] match_word(input logic [WORD_W-1:0] w,
                                                     input logic [2:0] len);
        logic [HITS_W-1:0] h;
        h = '0;
        h[HIT_OR]    = (len == 3'd2) && (w == KW_OR);
        h[HIT_UNION] = (len == 3'd5) && (w == KW_UNION);
        h[HIT_AND]   = (len == 3'd3) && (w == KW_AND);
        h[HIT_IN]    = (len == 3'd2) && (w == KW_IN);
        h[HIT_NOT]   = (len == 3'd3) && (w == KW_NOT);
        return h;
    endfunction

endpackage

>>> hdl/srts_if.sv
// Request channel interfaces for query bytes and scan verdicts.
interface srts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       char_valid;
    logic       last;

    modport source (output valid, output char_byte, output char_valid, output last,
                    input ready);
    modport sink (input valid, input char_byte, input char_valid, input last,
                  output ready);
endinterface

interface srts_out_if;
    logic       valid;
    logic       ready;
    logic       risky;
    logic [2:0] reason;

    modport source (output valid, output risky, output reason, input ready);
    modport sink (input valid, input risky, input reason, output ready);
endinterface

>>> hdl/srts_scan_state.sv
// Word tracking, keyword matching and verdict selection for one query.
module srts_scan_state
(
    input  logic               clk,
    input  logic               rst_n,
    input  srts_pkg::step_t    step,
    output srts_pkg::verdict_t verdict
);

    logic [srts_pkg::WORD_W-1:0] word_chars_reg, word_chars_next;
    logic [2:0]                  word_length_reg, word_length_next;
    logic                        special_seen_reg, special_seen_next;
    logic [srts_pkg::HITS_W-1:0] keyword_hits_reg, keyword_hits_next;

    logic [7:0]                  c;
    logic [srts_pkg::WORD_W-1:0] chars_a;
    logic [2:0]                  len_a;
    logic                        special_a;
    logic [srts_pkg::HITS_W-1:0] hits_a;
    logic [srts_pkg::HITS_W-1:0] hits_f;

    always_comb
    begin
        c         = srts_pkg::fold_case(step.char_byte);
        chars_a   = word_chars_reg;
        len_a     = word_length_reg;
        special_a = special_seen_reg;
        hits_a    = keyword_hits_reg;
        if (step.char_valid)
        begin
            special_a = special_seen_reg | srts_pkg::is_special_byte(c);
            if (srts_pkg::is_word_byte(c))
            begin
                chars_a = {word_chars_reg[srts_pkg::WORD_W-9:0], c};
                if (word_length_reg < srts_pkg::LEN_LONG)
                begin
                    len_a = word_length_reg + 3'd1;
                end
            end
            else
            begin
                hits_a  = keyword_hits_reg | srts_pkg::match_word(word_chars_reg,
                                                                   word_length_reg);
                chars_a = '0;
                len_a   = '0;
            end
        end
        hits_f = hits_a | srts_pkg::match_word(chars_a, len_a);
    end

    always_comb
    begin
        if (step.last)
        begin
            word_chars_next   = '0;
            word_length_next  = '0;
            special_seen_next = 1'b0;
            keyword_hits_next = '0;
        end
        else
        begin
            word_chars_next   = chars_a;
            word_length_next  = len_a;
            special_seen_next = special_a;
            keyword_hits_next = hits_a;
        end
    end

    always_comb
    begin
        if (special_a)
        begin
            verdict.reason = srts_pkg::REASON_SPECIAL;
        end
        else if (hits_f[srts_pkg::HIT_OR])
        begin
            verdict.reason = srts_pkg::REASON_OR;
        end
        else if (hits_f[srts_pkg::HIT_UNION])
        begin
            verdict.reason = srts_pkg::REASON_UNION;
        end
        else if (hits_f[srts_pkg::HIT_AND])
        begin
            verdict.reason = srts_pkg::REASON_AND;
        end
        else if (hits_f[srts_pkg::HIT_IN])
        begin
            verdict.reason = srts_pkg::REASON_IN;
        end
        else if (hits_f[srts_pkg::HIT_NOT])
        begin
            verdict.reason = srts_pkg::REASON_NOT;
        end
        else
        begin
            verdict.reason = srts_pkg::REASON_NONE;
        end
        verdict.risky = (verdict.reason != srts_pkg::REASON_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_chars_reg   <= '0;
            word_length_reg  <= '0;
            special_seen_reg <= 1'b0;
            keyword_hits_reg <= '0;
        end
        else if (step.fire)
        begin
            word_chars_reg   <= word_chars_next;
            word_length_reg  <= word_length_next;
            special_seen_reg <= special_seen_next;
            keyword_hits_reg <= keyword_hits_next;
        end
    end

endmodule

>>> hdl/sql_risk_token_scan.sv
// Top level of the SQL risk token scanner.
// A new request may be accepted in every cycle except when the stall below holds: a
// request is held in the input register while the scan state registers are updated, and
// the verdict for a query is loaded into the output register at the edge at which its last
// request leaves the input register. The only stall is a last request that finds a verdict
// still waiting to be taken; ordinary bytes keep flowing while a verdict waits.
module sql_risk_token_scan
(
    input logic        clk,
    input logic        rst_n,
    srts_in_if.sink    query,
    srts_out_if.source verdict
);

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_char_valid_reg;
    logic       s1_last_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_risky_reg;
    logic [2:0] out_reason_reg;

    logic               s1_go;
    logic               accept;
    srts_pkg::step_t    step;
    srts_pkg::verdict_t result;

    assign s1_go       = s1_valid_reg && (!s1_last_reg || !out_valid_reg || verdict.ready);
    assign query.ready = !s1_valid_reg || s1_go;
    assign accept      = query.valid && query.ready;

    assign step.fire       = s1_go;
    assign step.char_byte  = s1_byte_reg;
    assign step.char_valid = s1_char_valid_reg;
    assign step.last       = s1_last_reg;

    srts_scan_state u_state
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .verdict (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg       <= query.char_byte;
            s1_char_valid_reg <= query.char_valid;
            s1_last_reg       <= query.last;
        end
        if (s1_go && s1_last_reg)
        begin
            out_risky_reg  <= result.risky;
            out_reason_reg <= result.reason;
        end
    end

    assign verdict.valid  = out_valid_reg;
    assign verdict.risky  = out_risky_reg;
    assign verdict.reason = out_reason_reg;

endmodule

>>> hdl/srts_checker.sv
// Port checker for the SQL risk token scanner and its bind to the top level.
`include "sql_risk_token_scan_macros.svh"

module srts_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_risky,
    input logic [2:0] out_reason
);

    `SRTS_ASSERT_NEXT(a_out_valid_held, clk, rst_n, out_valid && !out_ready, out_valid, "Verdict request dropped while stalled.")
    `SRTS_ASSERT_NEXT(a_out_payload_held, clk, rst_n, out_valid && !out_ready, $stable(out_risky) && $stable(out_reason), "Verdict payload changed while stalled.")
    `SRTS_ASSERT_SAME(a_risky_matches_reason, clk, rst_n, out_valid, out_risky == (out_reason != srts_pkg::REASON_NONE), "Risky flag disagrees with reason code.")
    `SRTS_ASSERT_SAME(a_reason_known, clk, rst_n, out_valid, out_reason != 3'd7, "Reason code outside the defined set.")

endmodule

bind sql_risk_token_scan srts_checker u_srts_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .out_risky  (verdict.risky),
    .out_reason (verdict.reason)
);

>>> dv/srts_verdict_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the verdict of every query and compares it with the scanner's output.
module srts_verdict_checker
(
    input  logic        clk,
    input  logic        rst_n,
    srts_in_if          query,
    srts_out_if         verdict,
    output int unsigned errors,
    output int unsigned pending
);

    localparam int unsigned SAW_OR    = 0;
    localparam int unsigned SAW_UNION = 1;
    localparam int unsigned SAW_AND   = 2;
    localparam int unsigned SAW_IN    = 3;
    localparam int unsigned SAW_NOT   = 4;

    localparam logic [39:0] WORD_OR    = "or";
    localparam logic [39:0] WORD_UNION = "union";
    localparam logic [39:0] WORD_AND   = "and";
    localparam logic [39:0] WORD_IN    = "in";
    localparam logic [39:0] WORD_NOT   = "not";
    localparam logic [2:0]  LEN_OVER   = 3'd6;

    logic [39:0]           cur_word;
    logic [2:0]            cur_len;
    logic                  seen_special;
    logic [4:0]            word_hits;
    srts_pkg::verdict_t    expected_verdicts[$];

    function automatic logic punct_byte(input logic [7:0] c);
        case (c)
            "'", "_", "-", "+", "/", "=", "<", ">", "(", ")", ",", ".", "?",
            ":", "|", "[", "]", "{", "}", "@", "#", "$", "%", "&", "!", "^":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == "_";
    endfunction

    task automatic clear_scan();
        cur_word     = '0;
        cur_len      = '0;
        seen_special = 1'b0;
        word_hits    = '0;
    endtask

    task automatic close_word();
        if (cur_len == 3'd2 && cur_word == WORD_OR)
        begin
            word_hits[SAW_OR] = 1'b1;
        end
        else if (cur_len == 3'd5 && cur_word == WORD_UNION)
        begin
            word_hits[SAW_UNION] = 1'b1;
        end
        else if (cur_len == 3'd3 && cur_word == WORD_AND)
        begin
            word_hits[SAW_AND] = 1'b1;
        end
        else if (cur_len == 3'd2 && cur_word == WORD_IN)
        begin
            word_hits[SAW_IN] = 1'b1;
        end
        else if (cur_len == 3'd3 && cur_word == WORD_NOT)
        begin
            word_hits[SAW_NOT] = 1'b1;
        end
        cur_word = '0;
        cur_len  = '0;
    endtask

    task automatic absorb_byte(input logic [7:0] raw);
        logic [7:0] c;
        c = raw;
        if (c >= "A" && c <= "Z")
        begin
            c = c + 8'd32;
        end
        if (punct_byte(c))
        begin
            seen_special = 1'b1;
        end
        if (word_char(c))
        begin
            cur_word = {cur_word[31:0], c};
            if (cur_len < LEN_OVER)
            begin
                cur_len = cur_len + 3'd1;
            end
        end
        else
        begin
            close_word();
        end
    endtask

    function automatic srts_pkg::verdict_t query_verdict();
        srts_pkg::reason_t r;
        if (seen_special)
        begin
            r = srts_pkg::REASON_SPECIAL;
        end
        else if (word_hits[SAW_OR])
        begin
            r = srts_pkg::REASON_OR;
        end
        else if (word_hits[SAW_UNION])
        begin
            r = srts_pkg::REASON_UNION;
        end
        else if (word_hits[SAW_AND])
        begin
            r = srts_pkg::REASON_AND;
        end
        else if (word_hits[SAW_IN])
        begin
            r = srts_pkg::REASON_IN;
        end
        else if (word_hits[SAW_NOT])
        begin
            r = srts_pkg::REASON_NOT;
        end
        else
        begin
            r = srts_pkg::REASON_NONE;
        end
        return '{risky: (r != srts_pkg::REASON_NONE), reason: r};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        srts_pkg::verdict_t want;
        if (!rst_n)
        begin
            clear_scan();
            expected_verdicts.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (query.valid && query.ready)
            begin
                if (query.char_valid)
                begin
                    absorb_byte(query.char_byte);
                end
                if (query.last)
                begin
                    close_word();
                    expected_verdicts.push_back(query_verdict());
                    clear_scan();
                end
            end
            if (verdict.valid && verdict.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("verdict with no query pending: risky=%0b reason=%0d",
                                 verdict.risky, verdict.reason);
                    end
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict.risky !== want.risky || verdict.reason !== want.reason)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("verdict mismatch: expected risky=%0b reason=%0d, got risky=%0b reason=%0d",
                                     want.risky, want.reason, verdict.risky, verdict.reason);
                        end
                    end
                end
            end
            pending = expected_verdicts.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the SQL risk token scanner: clock, reset, query stimulus and the verdict.
module tb;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       char_valid;
        logic       last;
    } query_req_t;

    typedef enum int unsigned {
        READY_ALWAYS,
        READY_COIN,
        READY_THREE_OF_FOUR,
        READY_SPARSE,
        READY_PULSED
    } stall_mode_t;

    typedef enum int unsigned {
        SHAPE_WORDS,
        SHAPE_SPECIAL,
        SHAPE_NOISE,
        SHAPE_EMPTY
    } query_shape_t;

    localparam longint unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned     SCAN_ITEMS  = 826;
    localparam int unsigned     HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;

    srts_in_if  query_ch ();
    srts_out_if verdict_ch ();

    int unsigned     error_count;
    int unsigned     waiting_verdicts;
    longint unsigned cycle_count = 0;
    int unsigned     scan_items = 0;
    query_req_t      requests[$];

    string keywords[5] = '{"or", "union", "and", "in", "not"};
    string near_words[16] = '{"ore", "o", "uni", "unio", "an", "andy", "i", "inn",
                              "no", "nott", "xor", "or9", "select", "where", "t1", "42"};
    string separators = " \t*;\"~\\\n";
    string specials = "'_-+/=<>(),.?:|[]{}@#$%&!^";
    string word_alphabet = "abcdefghijklmnopqrstuvwxyz0123456789";

    sql_risk_token_scan u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_ch),
        .verdict (verdict_ch)
    );

    srts_verdict_checker u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .query   (query_ch),
        .verdict (verdict_ch),
        .errors  (error_count),
        .pending (waiting_verdicts)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        requests.push_back('{char_byte: b, char_valid: 1'b1, last: 1'b0});
        scan_items++;
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++)
        begin
            add_byte(s[k]);
        end
    endtask

    task automatic add_empty_item();
        requests.push_back('{char_byte: 8'($urandom_range(0, 255)), char_valid: 1'b0,
                             last: 1'b0});
    endtask

    task automatic end_query(input bit on_byte);
        if (on_byte && requests.size() > 0 && requests[requests.size() - 1].char_valid &&
            !requests[requests.size() - 1].last)
        begin
            requests[requests.size() - 1].last = 1'b1;
        end
        else
        begin
            requests.push_back('{char_byte: 8'($urandom_range(0, 255)), char_valid: 1'b0,
                                 last: 1'b1});
            scan_items++;
        end
    endtask

    function automatic string mixed_case(input string s);
        string r;
        r = s;
        for (int k = 0; k < r.len(); k++)
        begin
            if (r[k] >= "a" && r[k] <= "z" && $urandom_range(0, 1) == 1)
            begin
                r[k] = r[k] - 8'd32;
            end
        end
        return r;
    endfunction

    task automatic add_separator(input bit allow_special);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (allow_special && pick < 3)
        begin
            add_byte(specials[$urandom_range(0, specials.len() - 1)]);
        end
        else if (pick < 7)
        begin
            add_byte(separators[$urandom_range(0, separators.len() - 1)]);
        end
        else if (pick < 9)
        begin
            add_byte(8'($urandom_range(128, 255)));
        end
        else
        begin
            add_byte(8'($urandom_range(0, 31)));
        end
    endtask

    task automatic add_token();
        int unsigned pick;
        string kw;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            add_text(mixed_case(keywords[$urandom_range(0, 4)]));
        end
        else if (pick < 8)
        begin
            add_text(mixed_case(near_words[$urandom_range(0, 15)]));
        end
        else
        begin
            kw = keywords[$urandom_range(0, 4)];
            repeat (6 - kw.len() + $urandom_range(0, 2))
            begin
                add_byte(word_alphabet[$urandom_range(0, word_alphabet.len() - 1)]);
            end
            add_text(mixed_case(kw));
        end
    endtask

    task automatic build_directed();
        add_text("Or");
        end_query(1'b0);
        add_text("in");
        end_query(1'b1);
        add_empty_item();
        add_byte(8'hFF);
        add_text("NOT");
        end_query(1'b1);
        add_text("union");
        end_query(1'b1);
        add_text("and");
        end_query(1'b1);
        add_byte(8'h00);
        add_text("'");
        end_query(1'b1);
        add_text("xunion");
        end_query(1'b1);
    endtask

    task automatic build_random();
        query_shape_t shape;
        int unsigned  pick;
        int unsigned  tokens;
        while (scan_items < SCAN_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 12)
            begin
                shape = SHAPE_WORDS;
            end
            else if (pick < 15)
            begin
                shape = SHAPE_SPECIAL;
            end
            else if (pick < 19)
            begin
                shape = SHAPE_NOISE;
            end
            else
            begin
                shape = SHAPE_EMPTY;
            end
            if (shape == SHAPE_NOISE)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    add_byte(8'($urandom_range(0, 255)));
                end
            end
            else if (shape != SHAPE_EMPTY)
            begin
                tokens = $urandom_range(1, 4);
                for (int t = 0; t < tokens; t++)
                begin
                    if (t > 0 || $urandom_range(0, 3) == 0)
                    begin
                        add_separator(shape == SHAPE_SPECIAL);
                    end
                    if ($urandom_range(0, 11) == 0)
                    begin
                        add_empty_item();
                    end
                    add_token();
                end
                if ($urandom_range(0, 3) == 0)
                begin
                    add_separator(shape == SHAPE_SPECIAL);
                end
            end
            end_query($urandom_range(0, 1) == 1);
        end
    endtask

    initial
    begin
        int unsigned burst_left;
        rst_n                = 1'b0;
        query_ch.valid       = 1'b0;
        query_ch.char_byte   = 8'h00;
        query_ch.char_valid  = 1'b0;
        query_ch.last        = 1'b0;
        build_directed();
        build_random();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 12);
        foreach (requests[i])
        begin
            query_ch.valid      <= 1'b1;
            query_ch.char_byte  <= requests[i].char_byte;
            query_ch.char_valid <= requests[i].char_valid;
            query_ch.last       <= requests[i].last;
            @(posedge clk);
            while (!query_ch.ready)
            begin
                @(posedge clk);
            end
            burst_left--;
            if (burst_left == 0)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    query_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                         : $urandom_range(1, 12);
            end
        end
        query_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting_verdicts != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        stall_mode_t mode;
        int unsigned span;
        bit          held_off;
        held_off         = 1'b0;
        verdict_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_off && cycle_count > 300)
            begin
                held_off = 1'b1;
                verdict_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = stall_mode_t'($urandom_range(0, 4));
            span = $urandom_range(8, 80);
            for (int phase = 0; phase < span; phase++)
            begin
                case (mode)
                    READY_ALWAYS:        verdict_ch.ready <= 1'b1;
                    READY_COIN:          verdict_ch.ready <= 1'($urandom_range(0, 1));
                    READY_THREE_OF_FOUR: verdict_ch.ready <= (phase % 4) != 3;
                    READY_SPARSE:        verdict_ch.ready <= ($urandom_range(0, 7) == 0);
                    default:             verdict_ch.ready <= (phase % 7) < 2;
                endcase
                @(posedge clk);
            end
        end
    end

endmodule

>>> sql_risk_token_scan.f
+incdir+hdl
hdl/srts_pkg.sv
hdl/srts_if.sv
hdl/srts_scan_state.sv
hdl/sql_risk_token_scan.sv
hdl/srts_checker.sv
dv/srts_verdict_checker.sv
dv/tb.sv
